// File: src/pdp_pkg.sv
// Shared widths, constants and types of the packed-code dot product unit.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package pdp_pkg;

   localparam int LANE_COUNT    = 8;
   localparam int GROUP_WIDTH   = 64;
   localparam int CODE_WIDTH    = 8;
   localparam int PRODUCT_WIDTH = 2 * CODE_WIDTH;
   localparam int TREE_WIDTH    = PRODUCT_WIDTH + $clog2(LANE_COUNT);
   localparam int SUM_WIDTH     = 32;
   localparam int DEPTH_WIDTH   = 4;

   localparam logic [DEPTH_WIDTH-1:0] DEPTH_MIN   = 4'd4;
   localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX   = 4'd8;
   localparam logic [DEPTH_WIDTH-1:0] DEPTH_RESET = 4'd8;

   typedef logic [LANE_COUNT-1:0][PRODUCT_WIDTH-1:0] product_array_type;

   // occupancy of the product stage, handed to the merge stage
   typedef struct packed {
      logic valid;
      logic last;
   } stage_type;

   // flow control from the merge stage back to the front
   typedef struct packed {
      logic stage2_load;
      logic last_take;
   } merge_status_type;

endpackage

`default_nettype wire

// File: src/pdp_if.sv
// Valid/ready channel interfaces of the packed-code dot product unit.
// Depends on pdp_pkg for field widths.
`default_nettype none

interface pdp_req_if;
   logic                               valid;
   logic                               ready;
   logic [pdp_pkg::GROUP_WIDTH-1:0]    a_group;
   logic [pdp_pkg::GROUP_WIDTH-1:0]    b_group;
   logic                               last_group;

   modport source (output valid, output a_group, output b_group, output last_group,
                   input ready);
   modport sink   (input valid, input a_group, input b_group, input last_group,
                   output ready);
endinterface

interface pdp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pdp_pkg::SUM_WIDTH-1:0]      dot_sum;

   modport source (output valid, output dot_sum, input ready);
   modport sink   (input valid, input dot_sum, output ready);
endinterface

`default_nettype wire

// File: src/pdp_lane.sv
// One lane: unpacks code LANE_INDEX of both groups and registers their product.
// Depends on pdp_pkg for widths.
`default_nettype none

module pdp_lane #(
   parameter int LANE_INDEX = 0
) (
   input  wire logic                                 clock,
   input  wire logic                                 load,
   input  wire logic [pdp_pkg::DEPTH_WIDTH-1:0]      depth,
   input  wire logic [pdp_pkg::GROUP_WIDTH-1:0]      a_group,
   input  wire logic [pdp_pkg::GROUP_WIDTH-1:0]      b_group,
   output      logic [pdp_pkg::PRODUCT_WIDTH-1:0]    product
);

   localparam int CW = pdp_pkg::CODE_WIDTH;
   localparam int PW = pdp_pkg::PRODUCT_WIDTH;

   logic [CW-1:0] code_a;
   logic [CW-1:0] code_b;
   logic [PW-1:0] product_in;
   logic [PW-1:0] product_ff;

   // depth arrives already clamped to 4..8
   always_comb begin
      unique case (depth)
         4'd4: begin
            code_a = {4'd0, a_group[LANE_INDEX*4 +: 4]};
            code_b = {4'd0, b_group[LANE_INDEX*4 +: 4]};
         end
         4'd5: begin
            code_a = {3'd0, a_group[LANE_INDEX*5 +: 5]};
            code_b = {3'd0, b_group[LANE_INDEX*5 +: 5]};
         end
         4'd6: begin
            code_a = {2'd0, a_group[LANE_INDEX*6 +: 6]};
            code_b = {2'd0, b_group[LANE_INDEX*6 +: 6]};
         end
         4'd7: begin
            code_a = {1'd0, a_group[LANE_INDEX*7 +: 7]};
            code_b = {1'd0, b_group[LANE_INDEX*7 +: 7]};
         end
         default: begin
            code_a = a_group[LANE_INDEX*8 +: 8];
            code_b = b_group[LANE_INDEX*8 +: 8];
         end
      endcase
   end

   assign product_in = PW'(code_a) * PW'(code_b);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// File: src/pdp_merge.sv
// Merge stage: adder tree over the lane products, running sum and result register.
// Depends on pdp_pkg and pdp_rsp_if.
`default_nettype none

module pdp_merge (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pdp_pkg::stage_type           stage1,
   input  wire pdp_pkg::product_array_type   products,
   output      pdp_pkg::merge_status_type    status,
   pdp_rsp_if.source                         rsp_bus
);

   localparam int TW = pdp_pkg::TREE_WIDTH;
   localparam int SW = pdp_pkg::SUM_WIDTH;

   logic          valid2_ff, valid2_in;
   logic          last2_ff, last2_in;
   logic [TW-1:0] tree_ff, tree_in;
   logic [SW-1:0] acc_ff, acc_in;
   logic [SW-1:0] sum_next;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] dot_sum_ff;
   logic          out_free;
   logic          take2;
   logic          load2;

   always_comb begin
      tree_in = '0;
      for (int i = 0; i < pdp_pkg::LANE_COUNT; i++) begin
         tree_in = tree_in + TW'(products[i]);
      end
   end

   // a group that is not last needs no result slot
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign take2    = valid2_ff && (!last2_ff || out_free);
   assign load2    = !valid2_ff || take2;
   assign sum_next = acc_ff + SW'(tree_ff);

   always_comb begin
      valid2_in = load2 ? stage1.valid : valid2_ff;
      last2_in  = load2 ? stage1.last : last2_ff;
      acc_in    = acc_ff;
      if (take2) begin
         acc_in = last2_ff ? '0 : sum_next;
      end
      rsp_valid_in = rsp_valid_ff;
      if (take2 && last2_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff    <= 1'b0;
         last2_ff     <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid2_ff    <= valid2_in;
         last2_ff     <= last2_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load2) begin
         tree_ff <= tree_in;
      end
      if (take2 && last2_ff) begin
         dot_sum_ff <= sum_next;
      end
   end

   assign status.stage2_load = load2;
   assign status.last_take   = take2 && last2_ff;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.dot_sum    = dot_sum_ff;

endmodule

`default_nettype wire

// File: src/packed_code_dot_product_unit.sv
// Packed-code dot product unit: eight multiply lanes feed an adder tree and a running sum.
// A last group's result beat leaves the result register after the product and tree stages.
// Throughput: one group per cycle, stalled while a last group waits for the result slot.
// Reset clears the pipeline, the running sum and the result slot; depth_ff returns to 8.
// Depends on pdp_pkg, pdp_if, pdp_lane and pdp_merge.
`default_nettype none

module packed_code_dot_product_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [pdp_pkg::DEPTH_WIDTH-1:0]  csr_write_data,
   pdp_req_if.sink                               req_bus,
   pdp_rsp_if.source                             rsp_bus
);

   logic [pdp_pkg::DEPTH_WIDTH-1:0] depth_ff;
   logic [pdp_pkg::DEPTH_WIDTH-1:0] depth_eff;
   logic                            valid1_ff, valid1_in;
   logic                            last1_ff, last1_in;
   logic                            load1;
   pdp_pkg::stage_type              stage1;
   pdp_pkg::product_array_type      products;
   pdp_pkg::merge_status_type       status;

   // clamp the register to the supported layouts
   always_comb begin
      if (depth_ff < pdp_pkg::DEPTH_MIN) begin
         depth_eff = pdp_pkg::DEPTH_MIN;
      end else if (depth_ff > pdp_pkg::DEPTH_MAX) begin
         depth_eff = pdp_pkg::DEPTH_MAX;
      end else begin
         depth_eff = depth_ff;
      end
   end

   assign load1     = !valid1_ff || status.stage2_load;
   assign valid1_in = load1 ? req_bus.valid : valid1_ff;
   assign last1_in  = load1 ? req_bus.last_group : last1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= pdp_pkg::DEPTH_RESET;
         valid1_ff <= 1'b0;
         last1_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            depth_ff <= csr_write_data;
         end
         valid1_ff <= valid1_in;
         last1_ff  <= last1_in;
      end
   end

   assign req_bus.ready = load1;
   assign stage1.valid  = valid1_ff;
   assign stage1.last   = last1_ff;

   for (genvar g = 0; g < pdp_pkg::LANE_COUNT; g++) begin : g_lane
      pdp_lane #(
         .LANE_INDEX (g)
      ) u_lane (
         .clock   (clock),
         .load    (load1),
         .depth   (depth_eff),
         .a_group (req_bus.a_group),
         .b_group (req_bus.b_group),
         .product (products[g])
      );
   end

   pdp_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .stage1   (stage1),
      .products (products),
      .status   (status),
      .rsp_bus  (rsp_bus)
   );

   // a result beat appears only after a last group left the tree stage
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(status.last_take))
      else $error("result raised without a last group");

   // backpressure on the request side only with the product stage occupied
   a_ready_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> valid1_ff)
      else $error("request stalled with product stage empty");

   // an accepted beat always lands in the product stage
   a_beat_lands: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> valid1_ff)
      else $error("accepted beat lost");

endmodule

`default_nettype wire
